[rtl/lfps_pkg.sv]
package lfps_pkg;

   localparam int SENSOR_W   = 5;
   localparam int SPEED_W    = 8;
   localparam int ERR_W      = 8;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 10;
   localparam int INTEG_W    = LIMIT_W + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic signed [ERR_W-1:0] ERR_NONE    = 8'sd102;
   localparam logic signed [ERR_W-1:0] ERR_UNKNOWN = 8'sd103;

   localparam logic [GAIN_W-1:0]  GAIN_P_RESET     = 16'd6400;
   localparam logic [GAIN_W-1:0]  GAIN_I_RESET     = 16'd102;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 10'd100;
   localparam logic [SPEED_W-1:0] BASE_LEFT_RESET  = 8'd100;
   localparam logic [SPEED_W-1:0] BASE_RIGHT_RESET = 8'd100;
   localparam logic [SPEED_W-1:0] SPEED_MIN_RESET  = 8'd90;
   localparam logic [SPEED_W-1:0] SPEED_MAX_RESET  = 8'd200;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I         = 3'd1,
      CSR_INTEGRAL_LIMIT = 3'd2,
      CSR_BASE_LEFT      = 3'd3,
      CSR_BASE_RIGHT     = 3'd4,
      CSR_SPEED_MIN      = 3'd5,
      CSR_SPEED_MAX      = 3'd6
   } csr_index_type;

   typedef logic [SENSOR_W-1:0]     sensor_type;
   typedef logic [SPEED_W-1:0]      speed_type;
   typedef logic signed [ERR_W-1:0] line_err_type;

   // sensor pattern to line error, bit 0 is the rightmost sensor
   function automatic line_err_type line_error_of(input sensor_type bits);
      line_err_type e;
      case (bits)
         5'b00001: e = 8'sd4;
         5'b00011: e = 8'sd3;
         5'b00010: e = 8'sd2;
         5'b00110: e = 8'sd1;
         5'b00100: e = 8'sd0;
         5'b01100: e = -8'sd1;
         5'b01000: e = -8'sd2;
         5'b11000: e = -8'sd3;
         5'b10000: e = -8'sd4;
         5'b00000: e = ERR_NONE;
         5'b11111: e = 8'sd0;
         default:  e = ERR_UNKNOWN;
      endcase
      return e;
   endfunction

endpackage

[rtl/lfps_if.sv]
interface lfps_req_if;
   logic                       valid;
   logic                       ready;
   logic [lfps_pkg::SENSOR_W-1:0] sensor_bits;

   modport source (output valid, output sensor_bits, input ready);
   modport sink (input valid, input sensor_bits, output ready);
endinterface

interface lfps_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lfps_pkg::SPEED_W-1:0]      left_speed;
   logic [lfps_pkg::SPEED_W-1:0]      right_speed;
   logic signed [lfps_pkg::ERR_W-1:0] line_error;

   modport source (output valid, output left_speed, output right_speed,
                   output line_error, input ready);
   modport sink (input valid, input left_speed, input right_speed,
                 input line_error, output ready);
endinterface

[rtl/line_follower_pi_steering_unit.sv]
// an accepted item is registered in stage 1, then in stage 2 once the output is open
// one item per cycle unless stalled; the integral update and clamp are combinational
// stage 1 holds the line error and updated integral, stage 2 the clamped speeds
// reset: control registers load their default values, the integral clears to zero
// and both stages empty
module line_follower_pi_steering_unit (
   input  logic                                clock,
   input  logic                                reset,
   lfps_req_if.sink                            req_chan,
   lfps_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [lfps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lfps_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import lfps_pkg::*;

   localparam int ACC_W = INTEG_W + 1;
   localparam int QW    = 31;
   localparam int VW    = QW - 8;

   function automatic speed_type clamp_speed(input logic signed [QW-1:0] q,
                                             input speed_type lo,
                                             input speed_type hi);
      logic signed [QW-1:0] q_adj;
      logic signed [VW-1:0] v;
      logic signed [VW-1:0] lo_s;
      logic signed [VW-1:0] hi_s;
      speed_type            r;
      // round toward zero before the shift
      q_adj = q + $signed({{(QW-8){1'b0}}, {8{q[QW-1]}}});
      v     = q_adj[QW-1:8];
      lo_s  = $signed({{(VW-SPEED_W){1'b0}}, lo});
      hi_s  = $signed({{(VW-SPEED_W){1'b0}}, hi});
      if (v < lo_s) begin
         r = lo;
      end else if (v > hi_s) begin
         r = hi;
      end else begin
         r = v[SPEED_W-1:0];
      end
      return r;
   endfunction

   logic [GAIN_W-1:0]         gain_p_ff, gain_i_ff;
   logic [LIMIT_W-1:0]        limit_ff;
   speed_type                 base_left_ff, base_right_ff, speed_min_ff, speed_max_ff;
   logic signed [INTEG_W-1:0] integral_ff, integral_in;

   logic                      s1_valid_ff, s1_valid_in;
   line_err_type              err_ff;
   logic signed [INTEG_W-1:0] acc_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   speed_type                 left_ff, right_ff;
   line_err_type              line_err_ff;

   logic                      rsp_open, s1_adv, req_fire;
   line_err_type              err_new;
   logic signed [ACC_W-1:0]   acc_raw, lim_pos, lim_neg, acc_clamped;

   logic signed [QW-1:0]      gp_s, gi_s, err_s, acc_s, pi, base_l, base_r;
   speed_type                 left_new, right_new;

   // handshake
   assign rsp_open        = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv          = s1_valid_ff && rsp_open;
   assign req_chan.ready  = !s1_valid_ff || rsp_open;
   assign req_fire        = req_chan.valid && req_chan.ready;
   assign s1_valid_in     = req_chan.ready ? req_chan.valid : s1_valid_ff;
   assign rsp_valid_in    = rsp_open ? s1_valid_ff : rsp_valid_ff;

   // stage 1: error lookup and integral update
   assign err_new     = line_error_of(req_chan.sensor_bits);
   assign acc_raw     = ACC_W'(integral_ff) + ACC_W'(err_new);
   assign lim_pos     = $signed({{(ACC_W-LIMIT_W){1'b0}}, limit_ff});
   assign lim_neg     = -lim_pos;

   always_comb begin
      if (acc_raw < lim_neg) begin
         acc_clamped = lim_neg;
      end else if (acc_raw > lim_pos) begin
         acc_clamped = lim_pos;
      end else begin
         acc_clamped = acc_raw;
      end
   end

   assign integral_in = req_fire ? acc_clamped[INTEG_W-1:0] : integral_ff;

   // stage 2: pi terms and speed clamps
   assign gp_s   = $signed({{(QW-GAIN_W){1'b0}}, gain_p_ff});
   assign gi_s   = $signed({{(QW-GAIN_W){1'b0}}, gain_i_ff});
   assign err_s  = QW'(err_ff);
   assign acc_s  = QW'(acc_ff);
   assign pi     = gp_s * err_s + gi_s * acc_s;
   assign base_l = $signed({{(QW-SPEED_W-8){1'b0}}, base_left_ff, 8'b0});
   assign base_r = $signed({{(QW-SPEED_W-8){1'b0}}, base_right_ff, 8'b0});

   assign left_new  = clamp_speed(base_l - pi, speed_min_ff, speed_max_ff);
   assign right_new = clamp_speed(base_r + pi, speed_min_ff, speed_max_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= GAIN_P_RESET;
         gain_i_ff     <= GAIN_I_RESET;
         limit_ff      <= LIMIT_RESET;
         base_left_ff  <= BASE_LEFT_RESET;
         base_right_ff <= BASE_RIGHT_RESET;
         speed_min_ff  <= SPEED_MIN_RESET;
         speed_max_ff  <= SPEED_MAX_RESET;
         integral_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         integral_ff  <= integral_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_GAIN_P:         gain_p_ff     <= csr_wr_data[GAIN_W-1:0];
               CSR_GAIN_I:         gain_i_ff     <= csr_wr_data[GAIN_W-1:0];
               CSR_INTEGRAL_LIMIT: limit_ff      <= csr_wr_data[LIMIT_W-1:0];
               CSR_BASE_LEFT:      base_left_ff  <= csr_wr_data[SPEED_W-1:0];
               CSR_BASE_RIGHT:     base_right_ff <= csr_wr_data[SPEED_W-1:0];
               CSR_SPEED_MIN:      speed_min_ff  <= csr_wr_data[SPEED_W-1:0];
               CSR_SPEED_MAX:      speed_max_ff  <= csr_wr_data[SPEED_W-1:0];
               default:            ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         err_ff <= err_new;
         acc_ff <= acc_clamped[INTEG_W-1:0];
      end
      if (s1_adv) begin
         left_ff     <= left_new;
         right_ff    <= right_new;
         line_err_ff <= err_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.left_speed  = left_ff;
   assign rsp_chan.right_speed = right_ff;
   assign rsp_chan.line_error  = line_err_ff;

`ifndef SYNTHESIS
   a_integral_bound: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (ACC_W'(integral_ff) <= $signed({{(ACC_W-LIMIT_W){1'b0}}, $past(limit_ff)})
         && ACC_W'(integral_ff) >= -$signed({{(ACC_W-LIMIT_W){1'b0}}, $past(limit_ff)})))
      else $error("integral outside its limit after an item");

   a_stage1_err_legal: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> ((err_ff >= -8'sd4 && err_ff <= 8'sd4) || err_ff == ERR_NONE
         || err_ff == ERR_UNKNOWN))
      else $error("stage 1 line error not a table value");

   a_rsp_from_stage1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without an item in stage 1");

   a_left_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (left_ff == speed_min_ff || left_ff == speed_max_ff
         || (left_ff > speed_min_ff && left_ff < speed_max_ff)))
      else $error("left speed outside clamp");

   a_right_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (right_ff == speed_min_ff || right_ff == speed_max_ff
         || (right_ff > speed_min_ff && right_ff < speed_max_ff)))
      else $error("right speed outside clamp");
`endif

endmodule
